// ===== rtl/dkl_cipher_pkg.sv =====
// Package: types, constants and arithmetic helpers for the double key letter cipher.
`default_nettype none

package dkl_cipher_pkg;

   localparam int MAX_KEY_LETTERS = 12;
   localparam int SLOT_W          = 5;
   localparam int KEY_W           = SLOT_W * MAX_KEY_LETTERS;
   localparam int POS_W           = 4;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_W-1:0] MAX_LEN = POS_W'(MAX_KEY_LETTERS);

   // Register indexes of the configuration port
   localparam logic [2:0] CSR_DECRYPT_MODE = 3'd0;
   localparam logic [2:0] CSR_FIRST_KEY    = 3'd1;
   localparam logic [2:0] CSR_FIRST_LEN    = 3'd2;
   localparam logic [2:0] CSR_SECOND_KEY   = 3'd3;
   localparam logic [2:0] CSR_SECOND_LEN   = 3'd4;

   // Character codes
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_ALL_ONE = 8'hFF;
   localparam logic [7:0] CASE_FOLD    = 8'h20;

   // Encryption: offset + 53 - v, reduced mod 26
   localparam logic [6:0] ENC_BIAS = 7'd53;
   localparam logic [6:0] MOD_1X   = 7'd26;
   localparam logic [6:0] MOD_2X   = 7'd52;
   localparam logic [6:0] MOD_3X   = 7'd78;

   // Decryption: c + (0x61 + v) - 96 - 28 wraps to c + v - 27
   localparam logic [7:0] DEC_BIAS  = 8'd27;
   localparam logic [7:0] DEC_TRAP  = 8'd70;
   localparam logic [7:0] DEC_SUB   = 8'd122;
   localparam logic [7:0] DEC_LIMIT = 8'd97;
   localparam logic [7:0] DEC_WRAP  = 8'd26;

   typedef struct packed {
      logic             decrypt_mode;
      logic [KEY_W-1:0] first_key_letters;
      logic [POS_W-1:0] first_key_length;
      logic [KEY_W-1:0] second_key_letters;
      logic [POS_W-1:0] second_key_length;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } q_item_type;

   function automatic logic [POS_W-1:0] eff_len(input logic [POS_W-1:0] len);
      logic [POS_W-1:0] res;
      if (len == '0) begin
         res = POS_W'(1);
      end else if (len > MAX_LEN) begin
         res = MAX_LEN;
      end else begin
         res = len;
      end
      return res;
   endfunction

   function automatic logic [POS_W-1:0] cur_index(input logic [POS_W-1:0] pos,
                                                  input logic [POS_W-1:0] len);
      return (pos < eff_len(len)) ? pos : '0;
   endfunction

   function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] idx,
                                                 input logic [POS_W-1:0] len);
      logic [POS_W:0] inc;
      inc = {1'b0, idx} + (POS_W+1)'(1);
      return (inc >= {1'b0, eff_len(len)}) ? '0 : inc[POS_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] slot_value(input logic [KEY_W-1:0] letters,
                                                    input logic [POS_W-1:0] idx);
      logic [SLOT_W-1:0] res;
      res = '0;
      for (int i = 0; i < MAX_KEY_LETTERS; i++) begin
         if (idx == POS_W'(i)) begin
            res = letters[SLOT_W*i +: SLOT_W];
         end
      end
      return res;
   endfunction

   // Letter offset 0..25 in, offset 0..25 out
   function automatic logic [4:0] enc_step(input logic [4:0] off,
                                           input logic [SLOT_W-1:0] v);
      logic [6:0] t;
      logic [6:0] r;
      t = 7'(off) + ENC_BIAS - 7'(v);
      if (t >= MOD_3X) begin
         r = t - MOD_3X;
      end else if (t >= MOD_2X) begin
         r = t - MOD_2X;
      end else if (t >= MOD_1X) begin
         r = t - MOD_1X;
      end else begin
         r = t;
      end
      return r[4:0];
   endfunction

   function automatic logic [7:0] dec_step(input logic [7:0] c,
                                           input logic [SLOT_W-1:0] v);
      logic [7:0] s;
      logic [7:0] r;
      s = c + 8'(v) - DEC_BIAS;
      if (s == DEC_TRAP) begin
         r = DEC_SUB;
      end else if ($signed(s) < $signed(DEC_LIMIT)) begin
         r = s + DEC_WRAP;
      end else begin
         r = s;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/double_key_letter_cipher_top.sv =====
// Top level of the double key letter cipher: configuration registers and the front/back split.
// Use:
//   req_*  request channel, one byte per request (req_valid, req_stall, req_in_byte).
//          In encryption mode upper case is folded to lower case and any non-letter is
//          dropped; in decryption mode 0x0A and 0xFF are dropped. A dropped request
//          gives no response and leaves the key positions alone.
//   rsp_*  response channel (rsp_valid, rsp_stall, rsp_out_byte), at most one per request,
//          in request order.
//   csr_*  register writes (csr_valid, csr_ready, csr_index, csr_wdata); csr_ready is
//          always high. Write only while no request is in flight.
// Timing: one request per cycle sustained while rsp_stall stays low. An accepted request is
//   written into a two-entry queue, taken by the back end when its result register is free or
//   being drained, and then shown on rsp from the result register. The back end does the key
//   slot select and both cipher rounds combinationally between the queue head and that register.
// Stall: a valid result register holds while rsp_stall is high; the queue fills behind it and
//   req_stall rises once both entries are occupied.
// Reset (synchronous, active high): clears both key positions, empties the queue and the result
//   register; mode is encrypt, keys are all zero and both key lengths are one.
`default_nettype none

module double_key_letter_cipher_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [59:0] csr_wdata
);
   import dkl_cipher_pkg::*;

   logic             decrypt_mode_ff, decrypt_mode_in;
   logic [KEY_W-1:0] first_key_ff, first_key_in;
   logic [POS_W-1:0] first_len_ff, first_len_in;
   logic [KEY_W-1:0] second_key_ff, second_key_in;
   logic [POS_W-1:0] second_len_ff, second_len_in;
   logic             csr_write;
   cfg_type          cfg;
   q_item_type       q_push;
   q_item_type       q_head;
   logic             q_full;
   logic             q_pop;

   assign csr_ready = 1'b1;

   // Decode register writes; indexes beyond the list are dropped
   always_comb begin
      csr_write       = csr_valid && csr_ready;
      decrypt_mode_in = decrypt_mode_ff;
      first_key_in    = first_key_ff;
      first_len_in    = first_len_ff;
      second_key_in   = second_key_ff;
      second_len_in   = second_len_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_DECRYPT_MODE: decrypt_mode_in = csr_wdata[0];
            CSR_FIRST_KEY:    first_key_in    = csr_wdata[KEY_W-1:0];
            CSR_FIRST_LEN:    first_len_in    = csr_wdata[POS_W-1:0];
            CSR_SECOND_KEY:   second_key_in   = csr_wdata[KEY_W-1:0];
            CSR_SECOND_LEN:   second_len_in   = csr_wdata[POS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decrypt_mode_ff <= 1'b0;
         first_key_ff    <= '0;
         first_len_ff    <= POS_W'(1);
         second_key_ff   <= '0;
         second_len_ff   <= POS_W'(1);
      end else begin
         decrypt_mode_ff <= decrypt_mode_in;
         first_key_ff    <= first_key_in;
         first_len_ff    <= first_len_in;
         second_key_ff   <= second_key_in;
         second_len_ff   <= second_len_in;
      end
   end

   always_comb begin
      cfg.decrypt_mode       = decrypt_mode_ff;
      cfg.first_key_letters  = first_key_ff;
      cfg.first_key_length   = first_len_ff;
      cfg.second_key_letters = second_key_ff;
      cfg.second_key_length  = second_len_ff;
   end

   // Front end: classify and fold each request
   dkl_front u_front (
      .decrypt_mode (decrypt_mode_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .q_full       (q_full),
      .q_push       (q_push)
   );

   // Two-entry queue: lets the front keep accepting while the back holds a result
   dkl_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_full (q_full),
      .q_pop  (q_pop),
      .q_head (q_head)
   );

   // Back end: key positions, both cipher rounds, result register
   dkl_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte)
   );

endmodule

`default_nettype wire

// ===== rtl/dkl_front.sv =====
// Front end: accepts request bytes, folds case in encryption mode and drops bytes that give no result.
`default_nettype none

module dkl_front (
   input  wire logic                       decrypt_mode,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [7:0]                 req_in_byte,
   input  wire logic                       q_full,
   output dkl_cipher_pkg::q_item_type      q_push
);
   import dkl_cipher_pkg::*;

   logic       accept;
   logic       is_upper;
   logic       is_lower;
   logic [7:0] folded;
   logic       keep;

   always_comb begin
      req_stall = q_full;
      accept    = req_valid && !q_full;
      is_upper  = (req_in_byte >= CHAR_UPPER_A) && (req_in_byte <= CHAR_UPPER_Z);
      is_lower  = (req_in_byte >= CHAR_LOWER_A) && (req_in_byte <= CHAR_LOWER_Z);
      folded    = is_upper ? (req_in_byte + CASE_FOLD) : req_in_byte;
      if (decrypt_mode) begin
         keep = (req_in_byte != CHAR_NEWLINE) && (req_in_byte != CHAR_ALL_ONE);
      end else begin
         keep = is_upper || is_lower;
      end
      q_push.valid = accept && keep;
      q_push.data  = decrypt_mode ? req_in_byte : folded;
   end

endmodule

`default_nettype wire

// ===== rtl/dkl_queue.sv =====
// Short queue between the front end and the cipher back end.
`default_nettype none

module dkl_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dkl_cipher_pkg::q_item_type q_push,
   output logic                            q_full,
   input  wire logic                       q_pop,
   output dkl_cipher_pkg::q_item_type      q_head
);
   import dkl_cipher_pkg::*;

   logic [7:0]        entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_pop;

   always_comb begin
      q_full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
      q_head.valid = (count_ff != '0);
      q_head.data  = entries_ff[rd_ptr_ff];
      do_pop       = q_pop && q_head.valid;
      wr_ptr_in    = q_push.valid ? QPTR_W'(wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in    = do_pop ? QPTR_W'(rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in     = count_ff + QCNT_W'(q_push.valid) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.valid) begin
         entries_ff[wr_ptr_ff] <= q_push.data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push.valid)
      else $error("push into a full queue");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !q_push.valid) |=> (count_ff == $past(count_ff) - QCNT_W'(1)))
      else $error("pop did not reduce the count");

endmodule

`default_nettype wire

// ===== rtl/dkl_back.sv =====
// Back end: key positions, the two-key cipher and the result register.
`default_nettype none

module dkl_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dkl_cipher_pkg::cfg_type    cfg,
   input  wire dkl_cipher_pkg::q_item_type q_head,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [7:0]                      rsp_out_byte
);
   import dkl_cipher_pkg::*;

   logic [POS_W-1:0]  first_pos_ff, first_pos_in;
   logic [POS_W-1:0]  second_pos_ff, second_pos_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_byte_ff, rsp_byte_in;
   logic [POS_W-1:0]  idx1;
   logic [POS_W-1:0]  idx2;
   logic [SLOT_W-1:0] v1;
   logic [SLOT_W-1:0] v2;
   logic [7:0]        lower_off;
   logic [4:0]        enc_off;
   logic [7:0]        result;
   logic              take;

   always_comb begin
      idx1      = cur_index(first_pos_ff, cfg.first_key_length);
      idx2      = cur_index(second_pos_ff, cfg.second_key_length);
      v1        = slot_value(cfg.first_key_letters, idx1);
      v2        = slot_value(cfg.second_key_letters, idx2);
      lower_off = q_head.data - CHAR_LOWER_A;
      enc_off   = enc_step(enc_step(lower_off[4:0], v1), v2);
      if (cfg.decrypt_mode) begin
         result = dec_step(dec_step(q_head.data, v2), v1);
      end else begin
         result = CHAR_LOWER_A + 8'(enc_off);
      end

      // Take the head whenever the result register is free or being drained
      take  = q_head.valid && (!rsp_valid_ff || !rsp_stall);
      q_pop = take;

      first_pos_in  = take ? next_pos(idx1, cfg.first_key_length) : first_pos_ff;
      second_pos_in = take ? next_pos(idx2, cfg.second_key_length) : second_pos_ff;
      rsp_byte_in   = take ? result : rsp_byte_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_pos_ff  <= '0;
         second_pos_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         first_pos_ff  <= first_pos_in;
         second_pos_ff <= second_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   a_take_shows: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid)
      else $error("taken item not shown on the result port");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      (first_pos_ff < MAX_LEN) && (second_pos_ff < MAX_LEN))
      else $error("key position beyond the longest key");

   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(first_pos_ff) && $stable(second_pos_ff))
      else $error("key position moved without a result");

endmodule

`default_nettype wire

// ===== test/double_key_letter_cipher_top_tb.sv =====
// Self-checking testbench for the double key letter cipher: random traffic, stalls and key settings.
`timescale 1ns / 1ps

import dkl_cipher_pkg::*;

class cipher_tracker;
   bit               decrypt;
   bit [KEY_W-1:0]   key1;
   bit [KEY_W-1:0]   key2;
   bit [POS_W-1:0]   len1;
   bit [POS_W-1:0]   len2;
   bit [POS_W-1:0]   pos1;
   bit [POS_W-1:0]   pos2;
   bit [7:0]         pending_bytes[$];
   int               errors;
   int               produced;
   int               offered;

   function new();
      decrypt  = 1'b0;
      key1     = '0;
      key2     = '0;
      len1     = POS_W'(1);
      len2     = POS_W'(1);
      pos1     = '0;
      pos2     = '0;
      errors   = 0;
      produced = 0;
      offered  = 0;
   endfunction

   function void write_register(bit [2:0] idx, bit [59:0] data);
      case (idx)
         CSR_DECRYPT_MODE: decrypt = data[0];
         CSR_FIRST_KEY:    key1    = data[KEY_W-1:0];
         CSR_FIRST_LEN:    len1    = data[POS_W-1:0];
         CSR_SECOND_KEY:   key2    = data[KEY_W-1:0];
         CSR_SECOND_LEN:   len2    = data[POS_W-1:0];
         default: ;
      endcase
   endfunction

   // Zero counts as one letter, anything past the slot count is clipped
   function bit [POS_W-1:0] span(bit [POS_W-1:0] len);
      if (len == '0) return POS_W'(1);
      if (len > POS_W'(MAX_KEY_LETTERS)) return POS_W'(MAX_KEY_LETTERS);
      return len;
   endfunction

   function bit [7:0] shift_letter(bit [7:0] p, bit [4:0] v);
      int t;
      t = int'(p) - 97 + 53 - int'(v);
      return 8'(97 + t % 26);
   endfunction

   // Signed 8-bit wrap throughout, as the decipher rule demands
   function bit [7:0] unshift_letter(bit [7:0] c, bit [4:0] v);
      byte k;
      byte s;
      k = byte'(97 + int'(v));
      s = byte'(int'($signed(c)) - 96 + int'(k) - 28);
      if (s == 8'sd70) s = 8'sd122;
      if (s < 97) s = byte'(int'(s) + 26);
      return s;
   endfunction

   function void note_request(bit [7:0] b);
      bit [POS_W-1:0] i1;
      bit [POS_W-1:0] i2;
      bit [4:0]       v1;
      bit [4:0]       v2;
      bit [7:0]       p;
      bit [7:0]       r;
      int             n1;
      int             n2;
      offered++;
      i1 = (pos1 < span(len1)) ? pos1 : '0;
      i2 = (pos2 < span(len2)) ? pos2 : '0;
      v1 = key1[5*i1 +: 5];
      v2 = key2[5*i2 +: 5];
      if (!decrypt) begin
         p = b;
         if (p >= CHAR_UPPER_A && p <= CHAR_UPPER_Z) p = p + CASE_FOLD;
         if (p < CHAR_LOWER_A || p > CHAR_LOWER_Z) return;
         r = shift_letter(shift_letter(p, v1), v2);
      end else begin
         if (b == CHAR_NEWLINE || b == CHAR_ALL_ONE) return;
         r = unshift_letter(unshift_letter(b, v2), v1);
      end
      pending_bytes.push_back(r);
      produced++;
      n1 = int'(i1) + 1;
      n2 = int'(i2) + 1;
      pos1 = (n1 >= int'(span(len1))) ? '0 : POS_W'(n1);
      pos2 = (n2 >= int'(span(len2))) ? '0 : POS_W'(n2);
   endfunction

   function void check_reply(logic [7:0] got);
      bit [7:0] want;
      if (pending_bytes.size() == 0) begin
         $display("%0t: out_byte expected none actual %02h", $time, got);
         errors++;
         return;
      end
      want = pending_bytes.pop_front();
      if (got !== want) begin
         $display("%0t: out_byte expected %02h actual %02h", $time, want, got);
         errors++;
      end
   endfunction
endclass

module double_key_letter_cipher_top_tb;

   localparam int         ITEM_GOAL       = 1600;
   localparam int         SETTLE_CYCLES   = 6;
   localparam logic [2:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CSR_SPARE_LAST  = 3'd7;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [59:0] csr_wdata;

   cipher_tracker tracker;

   // Idle profile, one maximum gap per side; hold_cycles asks the receiver for one long hold-off
   int send_gap_max;
   int take_gap_max;
   int hold_cycles;

   // Encrypt edges: letter bounds, their neighbours, control and high bytes, and a mid-alphabet letter
   bit [7:0] enc_edges [12] = '{8'h41, 8'h5A, 8'h61, 8'h7A, 8'h40, 8'h5B,
                                8'h60, 8'h7B, 8'h00, 8'h80, 8'hFF, 8'h6D};
   // Decrypt edges: both dropped bytes, sign boundaries, letters and non-letters
   bit [7:0] dec_edges [10] = '{8'h0A, 8'hFF, 8'h00, 8'h7F, 8'h80,
                                8'hFE, 8'h61, 8'h7A, 8'h5B, 8'h01};
   bit [7:0] tail_edges [4] = '{8'h48, 8'h65, 8'h2E, 8'h7A};

   double_key_letter_cipher_top u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one request after a random gap and hold it until the block takes it.
   // Valid is only lowered when a gap follows, so back-to-back requests keep it high.
   task automatic offer_request(bit [7:0] b);
      int gap;
      gap = $urandom_range(send_gap_max, 0);
      if (gap > 0) begin
         req_valid   <= 1'b0;
         req_in_byte <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.note_request(b);
   endtask

   // Drop valid, wait for every response, then let any dropped request clear the pipe
   task automatic quiesce();
      req_valid <= 1'b0;
      do @(posedge clock); while (tracker.pending_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Leave csr_valid high; csr_idle lowers it once a batch of writes is done
   task automatic write_csr(bit [2:0] idx, bit [59:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      tracker.write_register(idx, data);
   endtask

   task automatic csr_idle();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: draw a stall per response, or take the long hold-off when asked for it
   task automatic take_responses();
      int n;
      forever begin
         if (hold_cycles > 0) begin
            n = hold_cycles;
            hold_cycles = 0;
         end else begin
            n = $urandom_range(take_gap_max, 0);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (rsp_valid !== 1'b1);
         tracker.check_reply(rsp_out_byte);
      end
   endtask

   function automatic bit [59:0] random_key();
      bit [59:0] k;
      case ($urandom_range(3, 0))
         0: k = '0;
         1: k = '1;
         2: k = {$urandom, $urandom};
         default: begin
            // every slot in the out-of-alphabet range
            for (int i = 0; i < MAX_KEY_LETTERS; i++) k[5*i +: 5] = 5'($urandom_range(31, 26));
         end
      endcase
      return k;
   endfunction

   function automatic bit [59:0] random_length();
      bit [59:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(4, 0))
         0: w[3:0] = 4'd0;
         1: w[3:0] = 4'd1;
         2: w[3:0] = 4'(MAX_KEY_LETTERS);
         3: w[3:0] = 4'd15;
         default: w[3:0] = 4'($urandom_range(15, 0));
      endcase
      return w;
   endfunction

   // Rewrite a random subset of the registers; keep the positions running across phases
   task automatic reconfigure();
      if ($urandom_range(3, 0) != 0) write_csr(CSR_DECRYPT_MODE, {$urandom, $urandom});
      if ($urandom_range(3, 0) != 0) write_csr(CSR_FIRST_KEY, random_key());
      if ($urandom_range(3, 0) != 0) write_csr(CSR_FIRST_LEN, random_length());
      if ($urandom_range(3, 0) != 0) write_csr(CSR_SECOND_KEY, random_key());
      if ($urandom_range(3, 0) != 0) write_csr(CSR_SECOND_LEN, random_length());
      if ($urandom_range(3, 0) == 0) begin
         write_csr(3'($urandom_range(CSR_SPARE_LAST, CSR_SPARE_FIRST)), {$urandom, $urandom});
      end
      csr_idle();
   endtask

   // Encrypt traffic is mostly letters so that most requests reach the cipher
   function automatic bit [7:0] pick_byte();
      bit [7:0] letter;
      letter = (($urandom_range(1, 0) == 0) ? CHAR_UPPER_A : CHAR_LOWER_A)
               + 8'($urandom_range(25, 0));
      if (!tracker.decrypt) begin
         return ($urandom_range(3, 0) != 0) ? letter : 8'($urandom);
      end
      case ($urandom_range(15, 0))
         0:       return CHAR_NEWLINE;
         1:       return CHAR_ALL_ONE;
         2, 3:    return letter;
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      bit [59:0] odd_key;
      int        phase;
      int        span_len;
      int        pause_at;

      tracker      = new();
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_in_byte  = '0;
      rsp_stall    = 1'b0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      send_gap_max = 12;
      take_gap_max = 12;
      hold_cycles  = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      fork
         take_responses();
      join_none

      // Directed: reset settings first, i.e. encrypt with both keys all 'a'
      foreach (enc_edges[i]) offer_request(enc_edges[i]);
      quiesce();

      // Decrypt with the top slot value everywhere in key one and values 26..31 in key two;
      // a zero length on key two acts as one letter
      for (int i = 0; i < MAX_KEY_LETTERS; i++) odd_key[5*i +: 5] = 5'(26 + i % 6);
      write_csr(CSR_DECRYPT_MODE, 60'd1);
      write_csr(CSR_FIRST_KEY, '1);
      write_csr(CSR_FIRST_LEN, 60'(MAX_KEY_LETTERS));
      write_csr(CSR_SECOND_KEY, odd_key);
      write_csr(CSR_SECOND_LEN, 60'd0);
      csr_idle();
      foreach (dec_edges[i]) offer_request(dec_edges[i]);
      quiesce();

      // Shorten key one below its position, overlong key two, and poke an unused index
      write_csr(CSR_DECRYPT_MODE, 60'd0);
      write_csr(CSR_FIRST_LEN, 60'd3);
      write_csr(CSR_SECOND_LEN, 60'd15);
      write_csr(CSR_SPARE_LAST, '1);
      csr_idle();
      foreach (tail_edges[i]) offer_request(tail_edges[i]);
      quiesce();

      // Random phases: fresh settings and idle profile each time, until enough requests are sent
      phase = 0;
      while (tracker.offered < ITEM_GOAL) begin
         reconfigure();
         send_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 12;
         take_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 12;
         span_len     = $urandom_range(120, 20);
         pause_at     = (phase == 1 || $urandom_range(4, 0) == 0)
                        ? $urandom_range(span_len - 1, 1) : -1;
         // Long receiver hold-off so the queue fills and req_stall rises
         if (phase == 0 || $urandom_range(5, 0) == 0) begin
            hold_cycles = $urandom_range(120, 60);
         end
         for (int i = 0; i < span_len; i++) begin
            if (i == pause_at) begin
               // hold the sender until every response is back
               req_valid <= 1'b0;
               do @(posedge clock); while (tracker.pending_bytes.size() != 0);
            end
            offer_request(pick_byte());
         end
         quiesce();
         phase++;
      end

      repeat (10) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_bytes.size() == 0) begin
         $display("double_key_letter_cipher_top: match");
      end else begin
         $display("double_key_letter_cipher_top: mismatch");
      end
      $finish;
   end

   // Watchdog: well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("double_key_letter_cipher_top: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/dkl_cipher_pkg.sv
rtl/dkl_front.sv
rtl/dkl_queue.sv
rtl/dkl_back.sv
rtl/double_key_letter_cipher_top.sv
test/double_key_letter_cipher_top_tb.sv
